@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CTKD_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ctkd check failed");

// Implication checked at every clock edge out of reset.
`define CTKD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctkd check failed");

`endif

@@ hw/rtl/ctkd_pkg.sv @@
// Package: types, constants and the arctangent table of the K-field evaluator.
`default_nettype none
package ctkd_pkg;

    localparam int unsigned PRESHIFT = 26;
    localparam logic signed [35:0] ANG_PI = 36'sd3373259426;
    localparam logic [63:0] KINV_Q24 = 64'd10188014;
    localparam logic signed [33:0] KINV_Q30 = 34'sd652032874;
    localparam logic [63:0] INV2PI_Q32 = 64'd683565276;
    localparam logic [40:0] MAG_CLIP = 41'h100_0000_0000;

    localparam logic [2:0] REG_TIP_X = 3'd0;
    localparam logic [2:0] REG_TIP_Y = 3'd1;
    localparam logic [2:0] REG_COMPONENT = 3'd2;
    localparam logic [2:0] REG_KAPPA = 3'd3;
    localparam logic [2:0] REG_INV_TWO_MU = 3'd4;

    typedef struct packed {
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] k_one;
        logic signed [31:0] k_two;
        logic signed [31:0] field_value;
    } ctkd_in_t;

    typedef struct packed {
        logic signed [31:0] residual;
        logic saturated;
    } ctkd_out_t;

    // One beat inside the vectoring pipeline.
    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [35:0] z;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] fv;
    } ctkd_vec_t;

    // atan(2^-idx) in Q30, rounded to nearest.
    function automatic logic signed [35:0] atan_q30(input int unsigned idx);
        logic signed [35:0] v;
        unique case (idx)
            0: v = 36'sd843314857;
            1: v = 36'sd497837829;
            2: v = 36'sd263043837;
            3: v = 36'sd133525159;
            4: v = 36'sd67021687;
            5: v = 36'sd33543516;
            6: v = 36'sd16775851;
            7: v = 36'sd8388437;
            8: v = 36'sd4194283;
            9: v = 36'sd2097149;
            10: v = 36'sd1048576;
            11: v = 36'sd524288;
            12: v = 36'sd262144;
            13: v = 36'sd131072;
            14: v = 36'sd65536;
            15: v = 36'sd32768;
            16: v = 36'sd16384;
            17: v = 36'sd8192;
            18: v = 36'sd4096;
            19: v = 36'sd2048;
            20: v = 36'sd1024;
            21: v = 36'sd512;
            22: v = 36'sd256;
            23: v = 36'sd128;
            24: v = 36'sd64;
            25: v = 36'sd32;
            26: v = 36'sd16;
            27: v = 36'sd8;
            28: v = 36'sd4;
            29: v = 36'sd2;
            30: v = 36'sd1;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ctkd_vec_cordic.sv @@
// Vectoring CORDIC pipeline: one micro-rotation per register stage.
`default_nettype none
module ctkd_vec_cordic
    import ctkd_pkg::*;
#(
    parameter int unsigned CORDIC_ITERS = 24
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_vld,
    input  wire ctkd_vec_t in_beat,
    output logic           out_vld,
    output ctkd_vec_t      out_beat
);

    logic      vld_reg [CORDIC_ITERS];
    ctkd_vec_t stg_reg [CORDIC_ITERS];

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
        logic      vld_in;
        ctkd_vec_t cur;
        ctkd_vec_t stg_next;

        if (i == 0) begin : g_head
            assign vld_in = in_vld;
            assign cur    = in_beat;
        end else begin : g_body
            assign vld_in = vld_reg[i-1];
            assign cur    = stg_reg[i-1];
        end

        always_comb
        begin
            stg_next = cur;
            if (cur.y > 0)
            begin
                stg_next.x = cur.x + (cur.y >>> i);
                stg_next.y = cur.y - (cur.x >>> i);
                stg_next.z = cur.z + atan_q30(i);
            end
            else
            begin
                stg_next.x = cur.x - (cur.y >>> i);
                stg_next.y = cur.y + (cur.x >>> i);
                stg_next.z = cur.z - atan_q30(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            stg_reg[i] <= stg_next;
        end
    end

    assign out_vld  = vld_reg[CORDIC_ITERS-1];
    assign out_beat = stg_reg[CORDIC_ITERS-1];

endmodule
`default_nettype wire

@@ hw/rtl/crack_tip_kfield_displacement_top.sv @@
// Top level: pipelined mixed-mode Williams crack-tip displacement residual.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------
//  node     | start, busy          | node (ctkd_in_t)
//  result   | done (strobe)        | result (ctkd_out_t)
//  config   | cfg_we               | cfg_index, cfg_data
//
// One node enters per cycle; busy is always low.
// The pipeline runs the input stage, the vectoring CORDIC, then 34 stages
// that run the rotation CORDIC beside the radius products and the 32-step
// square root, then nine stages of multipliers, the split 64x64 product and
// the final saturation. Reset clears the valid bits and loads the register
// defaults. Results are strobed for one cycle; there is no output stall.
`default_nettype none
module crack_tip_kfield_displacement_top
    import ctkd_pkg::*;
#(
    parameter int unsigned FRAC_BITS    = 16,
    parameter int unsigned CORDIC_ITERS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire ctkd_in_t    node,
    output logic             done,
    output ctkd_out_t        result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned POST    = 34;
    localparam int unsigned VSH     = 32 - FRAC_BITS;
    localparam int unsigned SH      = 2 * FRAC_BITS + 22;

    typedef struct packed {
        logic [63:0]        acc;
        logic [63:0]        rem;
        logic [63:0]        root;
        logic signed [33:0] c;
        logic signed [33:0] s;
        logic signed [35:0] z;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] fv;
    } post_t;

    // Configuration registers.
    logic signed [31:0] tip_x_reg;
    logic signed [31:0] tip_y_reg;
    logic               component_reg;
    logic signed [23:0] kappa_reg;
    logic [31:0]        inv_two_mu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tip_x_reg      <= '0;
            tip_y_reg      <= '0;
            component_reg  <= 1'b0;
            kappa_reg      <= 24'sd131072;
            inv_two_mu_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIP_X:      tip_x_reg      <= cfg_data;
                REG_TIP_Y:      tip_y_reg      <= cfg_data;
                REG_COMPONENT:  component_reg  <= cfg_data[0];
                REG_KAPPA:      kappa_reg      <= cfg_data[23:0];
                REG_INV_TWO_MU: inv_two_mu_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: offset, preshift and half-plane fold.
    logic              in_acc;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    ctkd_vec_t         v0_next;
    ctkd_vec_t         v0_reg;
    logic              v0_vld_reg;

    assign in_acc = start && !busy;

    always_comb
    begin
        dx = 33'(node.node_x) - 33'(tip_x_reg);
        dy = 33'(node.node_y) - 33'(tip_y_reg);
        xs = 64'(dx) <<< PRESHIFT;
        ys = 64'(dy) <<< PRESHIFT;
        v0_next.x  = xs;
        v0_next.y  = ys;
        v0_next.z  = '0;
        v0_next.k1 = node.k_one;
        v0_next.k2 = node.k_two;
        v0_next.fv = node.field_value;
        if (xs < 0)
        begin
            v0_next.z = (ys >= 0) ? ANG_PI : -ANG_PI;
            v0_next.x = -xs;
            v0_next.y = -ys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_vld_reg <= 1'b0;
        else
            v0_vld_reg <= in_acc;
    end

    always_ff @(posedge clk)
    begin
        v0_reg <= v0_next;
    end

    logic      vec_vld;
    ctkd_vec_t vec_beat;

    ctkd_vec_cordic #(
        .CORDIC_ITERS(CORDIC_ITERS)
    ) u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (v0_vld_reg),
        .in_beat (v0_reg),
        .out_vld (vec_vld),
        .out_beat(vec_beat)
    );

    // Radius, square root and rotation CORDIC side by side.
    post_t post_head;
    post_t post_reg [POST];
    logic  post_vld_reg [POST];

    always_comb
    begin
        post_head.acc  = vec_beat.x;
        post_head.rem  = '0;
        post_head.root = '0;
        post_head.c    = KINV_Q30;
        post_head.s    = '0;
        post_head.z    = vec_beat.z >>> 1;
        post_head.k1   = vec_beat.k1;
        post_head.k2   = vec_beat.k2;
        post_head.fv   = vec_beat.fv;
    end

    for (genvar j = 0; j < POST; j++) begin : g_post
        localparam int unsigned STEP = (j >= 2) ? j - 2 : 0;
        localparam logic [63:0] BIT  = 64'd1 << (62 - 2 * STEP);
        post_t cur;
        post_t post_next;
        logic  vld_in;

        if (j == 0) begin : g_head
            assign cur    = post_head;
            assign vld_in = vec_vld;
        end else begin : g_body
            assign cur    = post_reg[j-1];
            assign vld_in = post_vld_reg[j-1];
        end

        always_comb
        begin
            logic [63:0] trial;
            trial     = cur.root + BIT;
            post_next = cur;
            if (j == 0)
                post_next.acc = ({24'd0, cur.acc[63:24]} * KINV_Q24) >> PRESHIFT;
            else if (j == 1)
            begin
                post_next.rem  = (cur.acc * INV2PI_Q32) >> VSH;
                post_next.root = '0;
            end
            else if (cur.rem >= trial)
            begin
                post_next.rem  = cur.rem - trial;
                post_next.root = (cur.root >> 1) + BIT;
            end
            else
                post_next.root = cur.root >> 1;

            if (j < CORDIC_ITERS)
            begin
                if (cur.z >= 0)
                begin
                    post_next.c = cur.c - (cur.s >>> j);
                    post_next.s = cur.s + (cur.c >>> j);
                    post_next.z = cur.z - atan_q30(j);
                end
                else
                begin
                    post_next.c = cur.c + (cur.s >>> j);
                    post_next.s = cur.s - (cur.c >>> j);
                    post_next.z = cur.z + atan_q30(j);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                post_vld_reg[j] <= 1'b0;
            else
                post_vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            post_reg[j] <= post_next;
        end
    end

    post_t pt;
    assign pt = post_reg[POST-1];

    // Tail valid chain: A..I.
    logic [8:0] tv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= '0;
        else
            tv_reg <= {tv_reg[7:0], post_vld_reg[POST-1]};
    end

    // Stage A: squares.
    logic signed [67:0] a_cc_reg, a_ss_reg;
    logic signed [33:0] a_c_reg, a_s_reg;
    logic [31:0]        a_root_reg;
    logic signed [31:0] a_k1_reg, a_k2_reg, a_fv_reg;

    // Stage B: bracket terms.
    logic signed [39:0] b_cos30;
    logic signed [33:0] b_t1_next, b_t2_next;
    logic signed [33:0] b_kap24;
    logic signed [33:0] b_t1_reg, b_t2_reg;
    logic signed [33:0] b_c_reg, b_s_reg;
    logic [31:0]        b_root_reg;
    logic signed [31:0] b_k1_reg, b_k2_reg, b_fv_reg;

    // Stage C: trig times bracket.
    logic signed [67:0] c_p1_reg, c_p2_reg;
    logic [31:0]        c_root_reg;
    logic signed [31:0] c_k1_reg, c_k2_reg, c_fv_reg;

    // Stage D: F1, F2 and the common factor.
    logic signed [39:0] d_f1_reg, d_f2_reg;
    logic signed [39:0] d_f2_pos;
    logic [63:0]        d_common_reg;
    logic signed [31:0] d_k1_reg, d_k2_reg, d_fv_reg;

    // Stage E: K times F.
    logic signed [71:0] e_m1_reg, e_m2_reg;
    logic [63:0]        e_common_reg;
    logic signed [31:0] e_fv_reg;

    // Stage F: sign and magnitude.
    logic signed [63:0] f_a;
    logic [63:0]        f_amag_reg;
    logic               f_neg_reg;
    logic [63:0]        f_common_reg;
    logic signed [31:0] f_fv_reg;

    // Stage G: partial products.
    logic [63:0]        g_p00_reg, g_p01_reg, g_p10_reg, g_p11_reg;
    logic               g_neg_reg;
    logic signed [31:0] g_fv_reg;

    // Stage H: product, shift and clip.
    logic [127:0]       h_prod;
    logic [127:0]       h_shifted;
    logic [40:0]        h_mag_reg;
    logic               h_neg_reg;
    logic signed [31:0] h_fv_reg;

    // Stage I: subtract and saturate.
    logic signed [42:0] i_res;
    ctkd_out_t          result_next;
    ctkd_out_t          result_reg;

    assign b_kap24 = 34'(kappa_reg) <<< 8;

    always_comb
    begin
        b_cos30   = 40'((a_cc_reg - a_ss_reg) >>> 30);
        b_t1_next = b_kap24 - 34'(b_cos30 >>> 6);
        if (component_reg)
            b_t2_next = b_kap24 - 34'sd33554432 + 34'(b_cos30 >>> 6);
        else
            b_t2_next = b_kap24 + 34'sd33554432 + 34'(b_cos30 >>> 6);
    end

    assign d_f2_pos = 40'(c_p2_reg >>> 32);
    assign f_a      = 64'(e_m1_reg + e_m2_reg);

    always_comb
    begin
        h_prod = {64'd0, g_p00_reg}
               + ({64'd0, g_p01_reg} << 32)
               + ({64'd0, g_p10_reg} << 32)
               + {g_p11_reg, 64'd0};
        h_shifted = h_prod >> SH;
    end

    always_comb
    begin
        if (h_neg_reg)
            i_res = 43'(h_fv_reg) + 43'(signed'({2'b00, h_mag_reg}));
        else
            i_res = 43'(h_fv_reg) - 43'(signed'({2'b00, h_mag_reg}));
        result_next.saturated = 1'b0;
        result_next.residual  = i_res[31:0];
        if (i_res > 43'sd2147483647)
        begin
            result_next.residual  = 32'sh7fff_ffff;
            result_next.saturated = 1'b1;
        end
        else if (i_res < -43'sd2147483648)
        begin
            result_next.residual  = 32'sh8000_0000;
            result_next.saturated = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_cc_reg   <= pt.c * pt.c;
        a_ss_reg   <= pt.s * pt.s;
        a_c_reg    <= pt.c;
        a_s_reg    <= pt.s;
        a_root_reg <= pt.root[31:0];
        a_k1_reg   <= pt.k1;
        a_k2_reg   <= pt.k2;
        a_fv_reg   <= pt.fv;

        b_t1_reg   <= b_t1_next;
        b_t2_reg   <= b_t2_next;
        b_c_reg    <= a_c_reg;
        b_s_reg    <= a_s_reg;
        b_root_reg <= a_root_reg;
        b_k1_reg   <= a_k1_reg;
        b_k2_reg   <= a_k2_reg;
        b_fv_reg   <= a_fv_reg;

        c_p1_reg   <= (component_reg ? b_s_reg : b_c_reg) * b_t1_reg;
        c_p2_reg   <= (component_reg ? b_c_reg : b_s_reg) * b_t2_reg;
        c_root_reg <= b_root_reg;
        c_k1_reg   <= b_k1_reg;
        c_k2_reg   <= b_k2_reg;
        c_fv_reg   <= b_fv_reg;

        d_f1_reg     <= 40'(c_p1_reg >>> 32);
        d_f2_reg     <= component_reg ? -d_f2_pos : d_f2_pos;
        d_common_reg <= {32'd0, inv_two_mu_reg} * {32'd0, c_root_reg};
        d_k1_reg     <= c_k1_reg;
        d_k2_reg     <= c_k2_reg;
        d_fv_reg     <= c_fv_reg;

        e_m1_reg     <= d_k1_reg * d_f1_reg;
        e_m2_reg     <= d_k2_reg * d_f2_reg;
        e_common_reg <= d_common_reg;
        e_fv_reg     <= d_fv_reg;

        f_neg_reg    <= f_a < 0;
        f_amag_reg   <= (f_a < 0) ? 64'd0 - 64'(f_a) : 64'(f_a);
        f_common_reg <= e_common_reg;
        f_fv_reg     <= e_fv_reg;

        g_p00_reg <= {32'd0, f_amag_reg[31:0]}  * {32'd0, f_common_reg[31:0]};
        g_p01_reg <= {32'd0, f_amag_reg[31:0]}  * {32'd0, f_common_reg[63:32]};
        g_p10_reg <= {32'd0, f_amag_reg[63:32]} * {32'd0, f_common_reg[31:0]};
        g_p11_reg <= {32'd0, f_amag_reg[63:32]} * {32'd0, f_common_reg[63:32]};
        g_neg_reg <= f_neg_reg;
        g_fv_reg  <= f_fv_reg;

        h_mag_reg <= (h_shifted > {87'd0, MAG_CLIP}) ? MAG_CLIP : h_shifted[40:0];
        h_neg_reg <= g_neg_reg;
        h_fv_reg  <= g_fv_reg;

        result_reg <= result_next;
    end

    assign done   = tv_reg[8];
    assign result = result_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ctkd_checker.sv @@
// Port-level checker for the K-field evaluator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ctkd_checker
    import ctkd_pkg::*;
#(
    parameter int unsigned LAT = 68
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire ctkd_in_t    node,
    input wire logic        done,
    input wire ctkd_out_t   result,
    input wire logic        cfg_we,
    input wire logic [2:0]  cfg_index,
    input wire logic [31:0] cfg_data
);

    logic at_rail;

    assign at_rail = (result.residual == 32'sh7fff_ffff) ||
                     (result.residual == 32'sh8000_0000);

    // A result beat follows an accepted node beat by the pipeline latency.
    `CTKD_ASSERT_IMPL(a_done_has_start, done, $past(start, LAT))
    `CTKD_ASSERT_IMPL(a_sat_at_rail, done && result.saturated, at_rail)
    `CTKD_ASSERT_HOLDS(a_never_busy, !busy)

endmodule

bind crack_tip_kfield_displacement_top ctkd_checker #(
    .LAT(CORDIC_ITERS + 44)
) u_ctkd_checker (.*);
`default_nettype wire
